// ----- hw/rtl/arpc_pkg.sv -----
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int TableEntries = 16;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);

  // command codes
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_DEL    = 3'd1;
  localparam logic [2:0] CMD_TICK   = 3'd2;
  localparam logic [2:0] CMD_LOOKUP = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [15:0] AGE_LIMIT_RESET = 16'd300;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic        is_stat;
    logic [15:0] age;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   addr;
    entry_t            data;
  } wr_t;

endpackage

// ----- hw/rtl/arpc_if.sv -----
`timescale 1ns / 1ps

interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] ip_addr;
  logic [47:0] mac_addr;
  logic        is_static;
  logic [3:0]  slot_index;

  modport source (output valid, command, ip_addr, mac_addr, is_static, slot_index,
                  input ready);
  modport sink (input valid, command, ip_addr, mac_addr, is_static, slot_index,
                output ready);
endinterface

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] ip_out;
  logic [47:0] mac_out;
  logic        static_out;
  logic [3:0]  slot_out;
  logic        new_entry;
  logic [4:0]  entry_total;

  modport source (output valid, status, ip_out, mac_out, static_out, slot_out, new_entry,
                  entry_total, input ready);
  modport sink (input valid, status, ip_out, mac_out, static_out, slot_out, new_entry,
                entry_total, output ready);
endinterface

interface arpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/arp_cache_table.sv -----
`timescale 1ns / 1ps

// channel  dir  transaction
// req      in   command, ip_addr, mac_addr, is_static, slot_index
// rsp      out  status, ip_out, mac_out, static_out, slot_out, new_entry, entry_total
// cfg      in   data: age_limit, always ready
//
// delete and tick scan every entry, add and lookup stop at the first hit: one entry a cycle
// goes through the single read port of the entry store and the shared compare
// read by index of a filled slot goes through S_READ; clear, unused commands, add to an empty
// table and misses known at the request go straight to S_DONE
// req is ready only while no command is in flight; a waiting response does not hold off req
// rst is synchronous: the table becomes empty and age_limit returns to 300
// a stalled rsp holds only the final step, the scan itself never stalls

module arp_cache_table (
  input  logic        clk,
  input  logic        rst,
  arpc_req_if.sink    req,
  arpc_rsp_if.source  rsp,
  arpc_cfg_if.sink    cfg
);
  import arpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntFull = CntW'(TableEntries);

  logic [1:0]      state;
  logic [CntW-1:0] count;
  logic [15:0]     age_limit;

  // latched command
  logic [2:0]      cmd;
  logic [31:0]     ip;
  logic [47:0]     mac;
  logic            is_st;
  logic [IdxW-1:0] idx;

  // scan position (entry in rd_data), compaction write pointer, delete hit seen
  logic [IdxW-1:0] pos;
  logic [CntW-1:0] w;
  logic            found;

  // result being built
  logic [1:0]      res_status;
  logic [31:0]     res_ip;
  logic [47:0]     res_mac;
  logic            res_st;
  logic [IdxW-1:0] res_slot;
  logic            res_new;

  // output register
  logic            o_valid;
  logic [1:0]      o_status;
  logic [31:0]     o_ip;
  logic [47:0]     o_mac;
  logic            o_st;
  logic [3:0]      o_slot;
  logic            o_new;
  logic [4:0]      o_total;

  wr_t             wr;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;

  arpc_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.ip_out      = o_ip;
  assign rsp.mac_out     = o_mac;
  assign rsp.static_out  = o_st;
  assign rsp.slot_out    = o_slot;
  assign rsp.new_entry   = o_new;
  assign rsp.entry_total = o_total;

  // shared compare unit on the entry coming out of the store
  logic        ip_eq;
  logic        mac_eq;
  logic        exact;
  logic        reuse;
  logic [16:0] age_inc;
  logic        keep;
  logic        last;
  logic [CntW-1:0] w_next;

  // decisions taken right at the request transaction
  logic        add_empty;
  logic        req_miss;
  // output register takes the finished result
  logic        o_load;

  assign ip_eq   = (rd_data.ip == ip);
  assign mac_eq  = (rd_data.mac == mac);
  assign exact   = ip_eq && mac_eq;
  assign reuse   = !rd_data.is_stat && (ip_eq || mac_eq);
  assign age_inc = {1'b0, rd_data.age} + 17'd1;
  assign last    = (CntW'(pos) == count - CntOne);

  // empty table add appends at once; miss known without a scan
  assign add_empty = (req.command == CMD_ADD) && (count == '0);
  assign req_miss  = ((req.command inside {CMD_DEL, CMD_LOOKUP}) && (count == '0)) ||
                     ((req.command == CMD_READ) && (CntW'(req.slot_index) >= count));

  assign o_load = (state == S_DONE) && (!o_valid || rsp.ready);

  // compaction: delete drops the first ip hit, tick drops entries reaching the limit
  always_comb begin
    case (cmd)
      CMD_DEL:  keep = !(ip_eq && !found);
      CMD_TICK: keep = (age_inc < {1'b0, age_limit});
      default:  keep = 1'b1;
    endcase
  end

  assign w_next = keep ? w + CntOne : w;

  // store read address: next entry of the scan, or the slot for read by index
  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = pos + IdxW'(1);
    end else if (req.command == CMD_READ) begin
      rd_addr = IdxW'(req.slot_index);
    end else begin
      rd_addr = '0;
    end
  end

  // store write port
  always_comb begin
    wr = '0;
    if (state == S_IDLE && req.valid && req.command == CMD_ADD && count == '0) begin
      wr.en   = 1'b1;
      wr.addr = '0;
      wr.data = '{ip: req.ip_addr, mac: req.mac_addr, is_stat: req.is_static, age: 16'd0};
    end else if (state == S_SCAN) begin
      case (cmd)
        CMD_ADD: begin
          if (!exact && reuse) begin
            wr.en   = 1'b1;
            wr.addr = pos;
            wr.data = '{ip: ip, mac: mac, is_stat: is_st, age: rd_data.age};
          end else if (!exact && last && count != CntFull) begin
            wr.en   = 1'b1;
            wr.addr = IdxW'(count);
            wr.data = '{ip: ip, mac: mac, is_stat: is_st, age: 16'd0};
          end
        end
        CMD_DEL: begin
          wr.en   = keep;
          wr.addr = IdxW'(w);
          wr.data = rd_data;
        end
        CMD_TICK: begin
          wr.en   = keep;
          wr.addr = IdxW'(w);
          wr.data = '{ip: rd_data.ip, mac: rd_data.mac, is_stat: rd_data.is_stat,
                      age: age_inc[15:0]};
        end
        default: wr = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      age_limit <= AGE_LIMIT_RESET;
      o_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        age_limit <= cfg.data;
      end
      if (o_valid && rsp.ready && !o_load) begin
        o_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd        <= req.command;
            ip         <= req.ip_addr;
            mac        <= req.mac_addr;
            is_st      <= req.is_static;
            idx        <= IdxW'(req.slot_index);
            pos        <= '0;
            w          <= '0;
            found      <= 1'b0;
            res_status <= req_miss ? ST_MISS : ST_OK;
            res_ip     <= add_empty ? req.ip_addr : '0;
            res_mac    <= add_empty ? req.mac_addr : '0;
            res_st     <= add_empty ? req.is_static : 1'b0;
            res_slot   <= '0;
            res_new    <= add_empty;
            case (req.command)
              CMD_ADD: begin
                if (add_empty) begin
                  // empty table: append straight away
                  count <= CntOne;
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_DEL, CMD_LOOKUP: begin
                state <= req_miss ? S_DONE : S_SCAN;
              end
              CMD_TICK: begin
                state <= (count == '0) ? S_DONE : S_SCAN;
              end
              CMD_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              CMD_READ: begin
                state <= req_miss ? S_DONE : S_READ;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_READ: begin
          res_ip   <= rd_data.ip;
          res_mac  <= rd_data.mac;
          res_st   <= rd_data.is_stat;
          res_slot <= idx;
          state    <= S_DONE;
        end

        S_SCAN: begin
          pos <= pos + IdxW'(1);
          case (cmd)
            CMD_ADD: begin
              if (exact) begin
                res_ip   <= rd_data.ip;
                res_mac  <= rd_data.mac;
                res_st   <= rd_data.is_stat;
                res_slot <= pos;
                state    <= S_DONE;
              end else if (reuse) begin
                res_ip   <= ip;
                res_mac  <= mac;
                res_st   <= is_st;
                res_slot <= pos;
                state    <= S_DONE;
              end else if (last) begin
                if (count == CntFull) begin
                  res_status <= ST_FULL;
                end else begin
                  res_ip   <= ip;
                  res_mac  <= mac;
                  res_st   <= is_st;
                  res_slot <= IdxW'(count);
                  res_new  <= 1'b1;
                  count    <= count + CntOne;
                end
                state <= S_DONE;
              end
            end
            CMD_LOOKUP: begin
              if (ip_eq) begin
                res_ip   <= rd_data.ip;
                res_mac  <= rd_data.mac;
                res_st   <= rd_data.is_stat;
                res_slot <= pos;
                state    <= S_DONE;
              end else if (last) begin
                res_status <= ST_MISS;
                state      <= S_DONE;
              end
            end
            CMD_DEL: begin
              w <= w_next;
              if (ip_eq && !found) begin
                found    <= 1'b1;
                res_ip   <= rd_data.ip;
                res_mac  <= rd_data.mac;
                res_st   <= rd_data.is_stat;
                res_slot <= pos;
              end
              if (last) begin
                count      <= w_next;
                res_status <= (found || ip_eq) ? ST_OK : ST_MISS;
                state      <= S_DONE;
              end
            end
            CMD_TICK: begin
              w <= w_next;
              if (last) begin
                count <= w_next;
                state <= S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end

        S_DONE: begin
          // wait for the output register to free up
          if (o_load) begin
            o_valid  <= 1'b1;
            o_status <= res_status;
            o_ip     <= res_ip;
            o_mac    <= res_mac;
            o_st     <= res_st;
            o_slot   <= 4'(res_slot);
            o_new    <= res_new;
            o_total  <= 5'(count);
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntFull)
    else $error("entry count above table size");

  // one command in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("req ready right after a transaction");

  // scan stays inside the filled part of the table
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CntW'(pos) < count))
    else $error("scan past last entry");

  // table full only reported with a full table
  a_full_consistent: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.entry_total == 5'(CntFull) && !rsp.new_entry))
    else $error("table full response with room left");

  // an append always reports success
  a_new_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.new_entry) |-> (rsp.status == ST_OK))
    else $error("new entry with bad status");

endmodule

// ----- hw/rtl/arpc_store.sv -----
`timescale 1ns / 1ps

module arpc_store (
  input  logic                          clk,
  input  arpc_pkg::wr_t                 wr,
  input  logic [arpc_pkg::IdxW-1:0]     rd_addr,
  output arpc_pkg::entry_t              rd_data
);
  import arpc_pkg::*;

  entry_t mem [TableEntries];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- tb/arp_cache_table_tb.sv -----
`timescale 1ns / 1ps

module arp_cache_table_tb;
  import arpc_pkg::*;

  // the package names only the six used commands
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 262;
  localparam int POOL_SIZE       = 20;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        is_static;
    logic [3:0]  slot;
  } arp_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        is_static;
    logic [3:0]  slot;
    logic        new_entry;
    logic [4:0]  total;
  } arp_rsp_t;

  // shadow copy of the binding table and the queue of responses it predicts
  class arp_scoreboard;
    logic [31:0] ent_ip[TableEntries];
    logic [47:0] ent_mac[TableEntries];
    logic        ent_static[TableEntries];
    int unsigned ent_age[TableEntries];
    int unsigned ent_count;
    int unsigned age_limit;
    arp_rsp_t    expected_q[$];
    int          mismatches;

    function new();
      ent_count  = 0;
      age_limit  = AGE_LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void set_age_limit(logic [15:0] value);
      age_limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function arp_rsp_t entry_result(logic [1:0] status, int unsigned pos, bit has);
      arp_rsp_t r;
      r = '0;
      r.status = status;
      if (has) begin
        r.ip        = ent_ip[pos];
        r.mac       = ent_mac[pos];
        r.is_static = ent_static[pos];
        r.slot      = 4'(pos);
      end
      r.total = 5'(ent_count);
      return r;
    endfunction

    function int find_ip(logic [31:0] ip);
      for (int k = 0; k < int'(ent_count); k++) begin
        if (ent_ip[k] == ip) return k;
      end
      return -1;
    endfunction

    function void note_request(arp_req_t t);
      arp_rsp_t    r;
      int          hit;
      int unsigned w;
      int unsigned a;
      bit          done;
      done = 1'b0;
      r    = '0;
      case (t.command)
        CMD_ADD: begin
          // first entry that is an exact match, or dynamic and sharing ip or mac, wins
          for (int k = 0; k < int'(ent_count) && !done; k++) begin
            if (ent_ip[k] == t.ip && ent_mac[k] == t.mac) begin
              r    = entry_result(ST_OK, k, 1'b1);
              done = 1'b1;
            end else if (!ent_static[k] && (ent_ip[k] == t.ip || ent_mac[k] == t.mac)) begin
              ent_ip[k]     = t.ip;
              ent_mac[k]    = t.mac;
              ent_static[k] = t.is_static;
              r    = entry_result(ST_OK, k, 1'b1);
              done = 1'b1;
            end
          end
          if (!done) begin
            if (ent_count >= TableEntries) begin
              r = entry_result(ST_FULL, 0, 1'b0);
            end else begin
              ent_ip[ent_count]     = t.ip;
              ent_mac[ent_count]    = t.mac;
              ent_static[ent_count] = t.is_static;
              ent_age[ent_count]    = 0;
              ent_count++;
              r = entry_result(ST_OK, ent_count - 1, 1'b1);
              r.new_entry = 1'b1;
            end
          end
        end
        CMD_DEL: begin
          hit = find_ip(t.ip);
          if (hit >= 0) begin
            r = entry_result(ST_OK, hit, 1'b1);
            // close the gap, order of the rest kept
            for (int k = hit; k + 1 < int'(ent_count); k++) begin
              ent_ip[k]     = ent_ip[k + 1];
              ent_mac[k]    = ent_mac[k + 1];
              ent_static[k] = ent_static[k + 1];
              ent_age[k]    = ent_age[k + 1];
            end
            ent_count--;
            r.total = 5'(ent_count);
          end else begin
            r = entry_result(ST_MISS, 0, 1'b0);
          end
        end
        CMD_TICK: begin
          // age everything, drop what reaches the limit, static or not
          w = 0;
          for (int k = 0; k < int'(ent_count); k++) begin
            a = ent_age[k] + 1;
            if (a < age_limit) begin
              ent_ip[w]     = ent_ip[k];
              ent_mac[w]    = ent_mac[k];
              ent_static[w] = ent_static[k];
              ent_age[w]    = (a > 65535) ? 65535 : a;
              w++;
            end
          end
          ent_count = w;
          r = entry_result(ST_OK, 0, 1'b0);
        end
        CMD_LOOKUP: begin
          hit = find_ip(t.ip);
          if (hit >= 0) r = entry_result(ST_OK, hit, 1'b1);
          else r = entry_result(ST_MISS, 0, 1'b0);
        end
        CMD_CLEAR: begin
          ent_count = 0;
          r = entry_result(ST_OK, 0, 1'b0);
        end
        CMD_READ: begin
          if (t.slot < ent_count) r = entry_result(ST_OK, t.slot, 1'b1);
          else r = entry_result(ST_MISS, 0, 1'b0);
        end
        default: begin
          r = entry_result(ST_OK, 0, 1'b0);
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(arp_rsp_t got);
      arp_rsp_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response with nothing outstanding: status %0d ip %h mac %h",
                   $realtime, got.status, got.ip, got.mac);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.ip !== e.ip || got.mac !== e.mac ||
          got.is_static !== e.is_static || got.slot !== e.slot ||
          got.new_entry !== e.new_entry || got.total !== e.total) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: expected status %0d ip %h mac %h static %0d slot %0d new %0d total %0d",
                   $realtime, e.status, e.ip, e.mac, e.is_static, e.slot, e.new_entry, e.total);
          $display("%0t: actual   status %0d ip %h mac %h static %0d slot %0d new %0d total %0d",
                   $realtime, got.status, got.ip, got.mac, got.is_static, got.slot,
                   got.new_entry, got.total);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  arpc_req_if req_bus ();
  arpc_rsp_if rsp_bus ();
  arpc_cfg_if cfg_bus ();

  arp_cache_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  arp_scoreboard sb = new();

  logic [31:0] ip_pool[POOL_SIZE];
  logic [47:0] mac_pool[POOL_SIZE];

  // traffic shape, set by the phase sequencer
  bit snd_idle;
  bit rcv_stall;
  bit hold_req;
  int idle_pct;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every handshake seen at the rising edge feeds the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.set_age_limit(cfg_bus.data);
      if (req_bus.valid && req_bus.ready)
        sb.note_request('{command: req_bus.command, ip: req_bus.ip_addr,
                          mac: req_bus.mac_addr, is_static: req_bus.is_static,
                          slot: req_bus.slot_index});
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_result('{status: rsp_bus.status, ip: rsp_bus.ip_out,
                          mac: rsp_bus.mac_out, is_static: rsp_bus.static_out,
                          slot: rsp_bus.slot_out, new_entry: rsp_bus.new_entry,
                          total: rsp_bus.entry_total});
    end
  end

  // watchdog: too long without any transaction means the block hung
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      rsp_bus.ready = rcv_stall ? ($urandom_range(0, 99) >= idle_pct) : 1'b1;
    end
  end

  function automatic arp_req_t mk_req(logic [2:0] command, logic [31:0] ip, logic [47:0] mac,
                                      logic is_static, logic [3:0] slot);
    arp_req_t t;
    t.command   = command;
    t.ip        = ip;
    t.mac       = mac;
    t.is_static = is_static;
    t.slot      = slot;
    return t;
  endfunction

  // mostly pooled addresses so adds collide, overwrite and fill the table
  function automatic arp_req_t random_req();
    arp_req_t    t;
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (pick < 45)      t.command = CMD_ADD;
    else if (pick < 57) t.command = CMD_DEL;
    else if (pick < 67) t.command = CMD_TICK;
    else if (pick < 79) t.command = CMD_LOOKUP;
    else if (pick < 82) t.command = CMD_CLEAR;
    else if (pick < 94) t.command = CMD_READ;
    else if (pick < 97) t.command = CMD_RSVD6;
    else                t.command = CMD_RSVD7;
    idx  = $urandom_range(0, POOL_SIZE - 1);
    t.ip = ($urandom_range(0, 99) < 80) ? ip_pool[idx] : $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 50)      t.mac = mac_pool[idx];
    else if (pick < 80) t.mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    else                t.mac = {16'($urandom), 32'($urandom)};
    t.is_static = ($urandom_range(0, 99) < 25);
    t.slot      = 4'($urandom_range(0, 15));
    return t;
  endfunction

  // entered at a falling edge, leaves at the falling edge after acceptance
  task automatic send_req(arp_req_t t);
    if (snd_idle && $urandom_range(0, 99) < idle_pct) begin
      req_bus.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    req_bus.valid      = 1'b1;
    req_bus.command    = t.command;
    req_bus.ip_addr    = t.ip;
    req_bus.mac_addr   = t.mac;
    req_bus.is_static  = t.is_static;
    req_bus.slot_index = t.slot;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
  endtask

  // stop offering and let every outstanding response come back
  task automatic drain_responses();
    req_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_age_limit(logic [15:0] value);
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  initial begin
    logic [15:0] limits[PHASES];
    limits = '{16'd0, 16'd1, 16'd65535, 16'd3, 16'd300, 16'd12};

    rst                = 1'b1;
    snd_idle           = 1'b0;
    rcv_stall          = 1'b0;
    hold_req           = 1'b0;
    idle_pct           = 54;
    req_bus.valid      = 1'b0;
    req_bus.command    = CMD_ADD;
    req_bus.ip_addr    = '0;
    req_bus.mac_addr   = '0;
    req_bus.is_static  = 1'b0;
    req_bus.slot_index = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.data       = '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      ip_pool[k]  = $urandom;
      mac_pool[k] = {16'($urandom), 32'($urandom)};
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty-table misses, extremes, exact match, overwrite, static guard
    send_req(mk_req(CMD_READ, '0, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_LOOKUP, 32'h0102_0304, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_DEL, 32'h0102_0304, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_TICK, '0, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_ADD, '0, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_ADD, '1, '1, 1'b1, 4'd15));
    send_req(mk_req(CMD_ADD, '0, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_ADD, '0, 48'h1234_5678_9abc, 1'b1, 4'd0));
    send_req(mk_req(CMD_ADD, '1, 48'h0a0b_0c0d_0e0f, 1'b0, 4'd0));
    send_req(mk_req(CMD_LOOKUP, '1, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_READ, '0, '0, 1'b0, 4'd15));
    send_req(mk_req(CMD_READ, '0, '0, 1'b0, 4'd2));
    send_req(mk_req(CMD_DEL, '1, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_RSVD6, '1, '1, 1'b1, 4'd15));
    send_req(mk_req(CMD_RSVD7, '1, '1, 1'b1, 4'd15));
    // fill up, the last add finds the table full
    for (int k = 0; k < TableEntries - 1; k++)
      send_req(mk_req(CMD_ADD, 32'hc0a8_0100 + k, 48'h0200_0000_0000 + k, 1'b0, 4'd0));
    send_req(mk_req(CMD_TICK, '0, '0, 1'b0, 4'd0));
    send_req(mk_req(CMD_CLEAR, '0, '0, 1'b0, 4'd0));

    // random phases, each with its own age limit and traffic shape
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_responses();
      write_age_limit(limits[phase]);
      snd_idle  = (phase % 4 == 1) || (phase % 4 == 3);
      rcv_stall = (phase % 4 == 2) || (phase % 4 == 3);
      idle_pct  = (snd_idle && rcv_stall) ? 25 : 54;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long response hold-off while requests keep coming
        if (phase == 0 && i == 100) hold_req = 1'b1;
        // request side goes quiet until everything is answered
        if (phase == 1 && i == 150) drain_responses();
        send_req(random_req());
      end
    end

    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
